/* rtl/hpm_pkg.sv */
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared constants for the homography point map: fixed-point formats,
// register indexes, status codes and default widths.
// ----------------------------------------------------------------------------
package hpm_pkg;

	// default widths
	localparam int COORD_WIDTH = 16;
	localparam int COEF_WIDTH  = 32;

	// fixed-point fraction bits
	localparam int COORD_FRAC = 4;
	localparam int LIN_FRAC   = 16;
	localparam int PERSP_FRAC = 30;
	localparam int NUM_FRAC   = LIN_FRAC + COORD_FRAC;
	localparam int DEN_FRAC   = PERSP_FRAC + COORD_FRAC;
	localparam int QUO_SHIFT  = DEN_FRAC - NUM_FRAC + COORD_FRAC;

	// register file
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_XX = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_XY = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_XT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_YX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_YY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_YT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PX = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PY = 3'd7;

	// unit coefficient in Q16.16
	localparam int LIN_ONE = 65536;

	// status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

endpackage

/* rtl/hpm_mac.sv */
// ----------------------------------------------------------------------------
// hpm_mac
// Two-stage multiply-accumulate: six products in the first stage, the two
// numerators and the denominator in the second.
// ----------------------------------------------------------------------------
module hpm_mac #(
	parameter int COORD_WIDTH = hpm_pkg::COORD_WIDTH,
	parameter int COEF_WIDTH  = hpm_pkg::COEF_WIDTH,
	parameter int NUM_W       = 64
) (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic signed [COORD_WIDTH-1:0]               x,
	input  logic signed [COORD_WIDTH-1:0]               y,
	input  logic [hpm_pkg::NUM_REGS-1:0][COEF_WIDTH-1:0] coef,
	output logic signed [NUM_W-1:0]                     num_x,
	output logic signed [NUM_W-1:0]                     num_y,
	output logic signed [NUM_W-1:0]                     den
);

	localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;

	logic signed [PROD_W-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1, p_px_s1, p_py_s1;
	logic signed [PROD_W-1:0] t_x_s1, t_y_s1;

	// stage 1: products and scaled offsets
	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1 <= $signed(coef[hpm_pkg::REG_XX]) * x;
			p_xy_s1 <= $signed(coef[hpm_pkg::REG_XY]) * y;
			p_yx_s1 <= $signed(coef[hpm_pkg::REG_YX]) * x;
			p_yy_s1 <= $signed(coef[hpm_pkg::REG_YY]) * y;
			p_px_s1 <= $signed(coef[hpm_pkg::REG_PX]) * x;
			p_py_s1 <= $signed(coef[hpm_pkg::REG_PY]) * y;
			t_x_s1  <= PROD_W'($signed(coef[hpm_pkg::REG_XT])) <<< hpm_pkg::COORD_FRAC;
			t_y_s1  <= PROD_W'($signed(coef[hpm_pkg::REG_YT])) <<< hpm_pkg::COORD_FRAC;
		end
	end

	// stage 2: sums
	always_ff @(posedge clk) begin
		if (en) begin
			num_x <= NUM_W'(p_xx_s1) + NUM_W'(p_xy_s1) + NUM_W'(t_x_s1);
			num_y <= NUM_W'(p_yx_s1) + NUM_W'(p_yy_s1) + NUM_W'(t_y_s1);
			den   <= NUM_W'(p_px_s1) + NUM_W'(p_py_s1)
				+ (NUM_W'(1) << hpm_pkg::DEN_FRAC);
		end
	end

endmodule

/* rtl/hpm_div.sv */
// ----------------------------------------------------------------------------
// hpm_div
// Pipelined restoring divider for one coordinate: magnitudes, a range
// check, one quotient bit per stage, then sign and clamp.
// ----------------------------------------------------------------------------
module hpm_div #(
	parameter int COORD_WIDTH = hpm_pkg::COORD_WIDTH,
	parameter int NUM_W       = 64
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [NUM_W-1:0]       num,
	input  logic signed [NUM_W-1:0]       den,
	output logic signed [COORD_WIDTH-1:0] q,
	output logic                          sat
);

	localparam int W  = COORD_WIDTH;
	localparam int CW = NUM_W + hpm_pkg::QUO_SHIFT + W + 1;

	logic [NUM_W-1:0] n_sa, d_sa;
	logic             neg_sa;

	logic [CW-1:0]    rem_s [W+1];
	logic [NUM_W-1:0] d_s   [W+1];
	logic [W-1:0]     q_s   [W+1];
	logic             neg_s [W+1];
	logic             over_s[W+1];

	// stage a: signs and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			neg_sa <= num[NUM_W-1] ^ den[NUM_W-1];
			n_sa   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			d_sa   <= den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
		end
	end

	// stage b: quotient beyond the clamp bound
	always_ff @(posedge clk) begin
		if (en) begin
			over_s[0] <= ((CW'(n_sa) << hpm_pkg::QUO_SHIFT)
				>= ((CW'(d_sa) << (W-1)) + (neg_sa ? CW'(d_sa) : CW'(0))));
			rem_s[0]  <= CW'(n_sa) << hpm_pkg::QUO_SHIFT;
			d_s[0]    <= d_sa;
			neg_s[0]  <= neg_sa;
			q_s[0]    <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < W; j++) begin : g_bit
		localparam int K = W - 1 - j;
		logic [CW-1:0] dk;
		assign dk = CW'(d_s[j]) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j+1]    <= d_s[j];
				neg_s[j+1]  <= neg_s[j];
				over_s[j+1] <= over_s[j];
				if (rem_s[j] >= dk) begin
					rem_s[j+1] <= rem_s[j] - dk;
					q_s[j+1]   <= q_s[j] | (W'(1) << K);
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= q_s[j];
				end
			end
		end
	end

	// stage c: sign and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			sat <= over_s[W];
			if (over_s[W])
				q <= neg_s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			else
				q <= neg_s[W] ? $signed(-q_s[W]) : $signed(q_s[W]);
		end
	end

endmodule

/* rtl/homography_point_map.sv */
// ----------------------------------------------------------------------------
// homography_point_map
// Projective point transform through a 3x3 homography with unit corner.
// ----------------------------------------------------------------------------
// One point enters per cycle unless the output stalls, and passes through two
// multiply-accumulate stages, a magnitude stage, a range-check stage, one
// divider stage per quotient bit, a sign and clamp stage and the output
// register. The whole pipeline moves together and holds while a result waits
// on m_tready. The user must write coefficients through the cfg port only
// while no item is in flight; the block does not enforce this. After reset
// the block is the identity map.
module homography_point_map #(
	parameter int COORD_WIDTH = hpm_pkg::COORD_WIDTH,
	parameter int COEF_WIDTH  = hpm_pkg::COEF_WIDTH,
	localparam int IN_W  = ((2*COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((2*COORD_WIDTH + hpm_pkg::STATUS_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,   // in_x, in_y
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata,   // out_x, out_y, status
	input  logic                          cfg_wen,
	input  logic [hpm_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [COEF_WIDTH-1:0]         cfg_data
);

	localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
	localparam int NUM_W  = (PROD_W > hpm_pkg::DEN_FRAC + 1 ? PROD_W
		: hpm_pkg::DEN_FRAC + 1) + 2;
	localparam int DIV_L  = COORD_WIDTH + 3;
	localparam int LAT    = 2 + DIV_L + 1;

	logic [hpm_pkg::NUM_REGS-1:0][COEF_WIDTH-1:0] coef_q;
	logic [LAT-1:0]   vld_q;
	logic [DIV_L-1:0] zero_q;
	logic             adv;

	logic signed [NUM_W-1:0]       num_x, num_y, den;
	logic signed [COORD_WIDTH-1:0] qx, qy;
	logic                          sat_x, sat_y;
	logic [hpm_pkg::STATUS_W-1:0]  status;
	logic [OUT_W-1:0]              out_d;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hpm_pkg::NUM_REGS; i++)
				coef_q[i] <= (i == hpm_pkg::REG_XX || i == hpm_pkg::REG_YY)
					? COEF_WIDTH'(hpm_pkg::LIN_ONE) : '0;
		end else if (cfg_wen) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// pipeline moves whenever the output register is free or being taken
	assign adv      = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	hpm_mac #(
		.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .NUM_W(NUM_W)
	) u_mac (
		.clk(clk), .en(adv),
		.x(s_tdata[COORD_WIDTH-1:0]), .y(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.coef(coef_q), .num_x(num_x), .num_y(num_y), .den(den)
	);

	hpm_div #(.COORD_WIDTH(COORD_WIDTH), .NUM_W(NUM_W)) u_div_x (
		.clk(clk), .en(adv), .num(num_x), .den(den), .q(qx), .sat(sat_x)
	);

	hpm_div #(.COORD_WIDTH(COORD_WIDTH), .NUM_W(NUM_W)) u_div_y (
		.clk(clk), .en(adv), .num(num_y), .den(den), .q(qy), .sat(sat_y)
	);

	// zero denominator flag travels alongside the dividers
	always_ff @(posedge clk) begin
		if (adv)
			zero_q <= {zero_q[DIV_L-2:0], (den == '0)};
	end

	// output register
	always_comb begin
		if (zero_q[DIV_L-1])
			status = hpm_pkg::ST_ZERO;
		else if (sat_x || sat_y)
			status = hpm_pkg::ST_SAT;
		else
			status = hpm_pkg::ST_OK;
	end

	always_comb begin
		out_d = '0;
		out_d[hpm_pkg::STATUS_W+2*COORD_WIDTH-1:2*COORD_WIDTH] = status;
		if (!zero_q[DIV_L-1]) begin
			out_d[COORD_WIDTH-1:0]             = qx;
			out_d[2*COORD_WIDTH-1:COORD_WIDTH] = qy;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			m_tdata <= out_d;
	end

endmodule

/* rtl/hpm_checker.sv */
// ----------------------------------------------------------------------------
// hpm_checker
// Port-level checks on the point map's result stream.
// ----------------------------------------------------------------------------
module hpm_checker #(
	parameter int COORD_WIDTH = hpm_pkg::COORD_WIDTH,
	parameter int OUT_W = 40
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic [hpm_pkg::STATUS_W-1:0] st;
	logic [COORD_WIDTH-1:0]       ox, oy;
	logic [COORD_WIDTH-1:0]       vmax, vmin;

	assign ox   = m_tdata[COORD_WIDTH-1:0];
	assign oy   = m_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign st   = m_tdata[hpm_pkg::STATUS_W+2*COORD_WIDTH-1:2*COORD_WIDTH];
	assign vmax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	assign vmin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// status code is one of the defined ones
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == hpm_pkg::ST_OK || st == hpm_pkg::ST_SAT
			|| st == hpm_pkg::ST_ZERO))
		else $error("undefined status");

	// zero denominator gives a zero point
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == hpm_pkg::ST_ZERO |-> ox == '0 && oy == '0)
		else $error("zero denominator with nonzero point");

	// a clamped result sits on a range bound
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == hpm_pkg::ST_SAT
		|-> (ox == vmax || ox == vmin || oy == vmax || oy == vmin))
		else $error("saturation without a bound value");

endmodule

bind homography_point_map hpm_checker #(
	.COORD_WIDTH(COORD_WIDTH), .OUT_W(OUT_W)
) u_hpm_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata)
);
